// ===== src/pcx_pkg.sv =====
// Shared types and constants for the PCX RLE image decoder.
// Used by every module under src; depends on nothing.
package pcx_pkg;

  localparam int unsigned HDR_BYTES = 128;
  localparam int unsigned COL_W     = 10;
  localparam int unsigned LINE_W    = 9;
  localparam int unsigned RUN_W     = 6;
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;

  // Header field offsets and expected values
  localparam logic [7:0] HDR_OFS_MANUF   = 8'd0;
  localparam logic [7:0] HDR_OFS_VERSION = 8'd1;
  localparam logic [7:0] HDR_OFS_ENCODE  = 8'd2;
  localparam logic [7:0] HDR_OFS_BPP     = 8'd3;
  localparam logic [7:0] HDR_OFS_XMAX_LO = 8'd8;
  localparam logic [7:0] HDR_OFS_XMAX_HI = 8'd9;
  localparam logic [7:0] HDR_OFS_YMAX_LO = 8'd10;
  localparam logic [7:0] HDR_OFS_YMAX_HI = 8'd11;
  localparam logic [7:0] HDR_OFS_LAST    = 8'(HDR_BYTES - 1);

  localparam logic [7:0] HDR_MANUF   = 8'h0A;
  localparam logic [7:0] HDR_VERSION = 8'd5;
  localparam logic [7:0] HDR_ENCODE  = 8'd1;
  localparam logic [7:0] HDR_BPP     = 8'd8;

  localparam logic [7:0] RUN_MARK = 8'hC0;
  localparam logic [7:0] RUN_MASK = 8'h3F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        pixel;
    logic [COL_W-1:0]  column;
    logic [LINE_W-1:0] line;
    logic              run_end;
    logic              image_end;
    logic              bad_format;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_HDR = 2'd0,
    CMD_BAD = 2'd1,
    CMD_RUN = 2'd2
  } cmd_kind_t;

  // Work handed from the byte parser to the pixel expander
  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        value;
    logic [RUN_W-1:0]  count;
    logic [COL_W-1:0]  max_col;
    logic [LINE_W-1:0] max_line;
  } cmd_t;

endpackage

// ===== src/pcx_front.sv =====
// Byte parser: header check and run-count detection, emits commands.
// Depends on pcx_pkg.
module pcx_front import pcx_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 640,
  parameter int unsigned MAX_HEIGHT = 480
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_item_t in_item,
  input  logic     cmd_full,
  output logic     in_full,
  output logic     cmd_push,
  output cmd_t     cmd
);

  localparam logic [15:0] MaxW = 16'(MAX_WIDTH);
  localparam logic [15:0] MaxH = 16'(MAX_HEIGHT);

  logic [7:0]       hdr_pos_r, hdr_pos_nxt;
  logic [15:0]      max_col_r, max_col_nxt;
  logic [15:0]      max_line_r, max_line_nxt;
  logic             hdr_ok_r, hdr_ok_nxt;
  logic             run_wait_r, run_wait_nxt;
  logic [RUN_W-1:0] run_len_r, run_len_nxt;

  logic       accept;
  logic [7:0] pos;
  logic [7:0] d;
  logic       ok;
  logic       rw;
  logic       final_ok;

  assign in_full = cmd_full;
  assign accept  = in_push & ~cmd_full;
  assign d       = in_item.data_byte;
  assign pos     = in_item.start_of_file ? 8'd0 : hdr_pos_r;
  assign ok      = in_item.start_of_file ? 1'b1 : hdr_ok_r;
  assign rw      = in_item.start_of_file ? 1'b0 : run_wait_r;

  always_comb begin
    hdr_pos_nxt  = hdr_pos_r;
    max_col_nxt  = max_col_r;
    max_line_nxt = max_line_r;
    hdr_ok_nxt   = hdr_ok_r;
    run_wait_nxt = run_wait_r;
    run_len_nxt  = run_len_r;
    cmd_push     = 1'b0;
    cmd          = '0;
    final_ok     = 1'b0;
    if (accept) begin
      hdr_ok_nxt   = ok;
      run_wait_nxt = rw;
      if (pos < 8'(HDR_BYTES)) begin
        case (pos)
          HDR_OFS_MANUF:   if (d != HDR_MANUF) hdr_ok_nxt = 1'b0;
          HDR_OFS_VERSION: if (d != HDR_VERSION) hdr_ok_nxt = 1'b0;
          HDR_OFS_ENCODE:  if (d != HDR_ENCODE) hdr_ok_nxt = 1'b0;
          HDR_OFS_BPP:     if (d != HDR_BPP) hdr_ok_nxt = 1'b0;
          HDR_OFS_XMAX_LO: max_col_nxt  = {max_col_r[15:8], d};
          HDR_OFS_XMAX_HI: max_col_nxt  = {d, max_col_r[7:0]};
          HDR_OFS_YMAX_LO: max_line_nxt = {max_line_r[15:8], d};
          HDR_OFS_YMAX_HI: max_line_nxt = {d, max_line_r[7:0]};
          default: ;
        endcase
        hdr_pos_nxt = pos + 8'd1;
        if (pos == HDR_OFS_LAST) begin
          final_ok = hdr_ok_nxt && !max_col_r[15] && (max_col_r < MaxW)
                     && !max_line_r[15] && (max_line_r < MaxH);
          hdr_ok_nxt   = final_ok;
          cmd_push     = 1'b1;
          cmd.kind     = final_ok ? CMD_HDR : CMD_BAD;
          cmd.max_col  = final_ok ? max_col_r[COL_W-1:0] : '0;
          cmd.max_line = final_ok ? max_line_r[LINE_W-1:0] : '0;
        end
      end else if (ok) begin
        if (rw) begin
          // value byte of a run; a zero-length run yields nothing
          run_wait_nxt = 1'b0;
          cmd_push     = (run_len_r != '0);
          cmd.kind     = CMD_RUN;
          cmd.value    = d;
          cmd.count    = run_len_r;
        end else if ((d & RUN_MARK) == RUN_MARK) begin
          run_wait_nxt = 1'b1;
          run_len_nxt  = RUN_W'(d & RUN_MASK);
        end else begin
          cmd_push  = 1'b1;
          cmd.kind  = CMD_RUN;
          cmd.value = d;
          cmd.count = RUN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r  <= '0;
      hdr_ok_r   <= 1'b1;
      run_wait_r <= 1'b0;
    end else begin
      hdr_pos_r  <= hdr_pos_nxt;
      hdr_ok_r   <= hdr_ok_nxt;
      run_wait_r <= run_wait_nxt;
    end
    max_col_r  <= max_col_nxt;
    max_line_r <= max_line_nxt;
    run_len_r  <= run_len_nxt;
  end

endmodule

// ===== src/pcx_cmd_fifo.sv =====
// Short command queue between the byte parser and the pixel expander.
// Depends on pcx_pkg.
module pcx_cmd_fifo import pcx_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic empty,
  output cmd_t head
);

  localparam int unsigned CntW = $clog2(CMD_DEPTH + 1);

  cmd_t                 mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]      cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full    = (cnt_r == CntW'(CMD_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  function automatic logic [CMD_PTR_W-1:0] ptr_inc(input logic [CMD_PTR_W-1:0] p);
    ptr_inc = (p == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== src/pcx_back.sv =====
// Pixel expander: turns commands into positioned pixels, one per cycle while out_pop keeps the output free.
// Depends on pcx_pkg.
module pcx_back import pcx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_empty,
  input  cmd_t      head,
  output logic      cmd_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [COL_W-1:0]  maxc_r, maxc_nxt;
  logic [LINE_W-1:0] maxl_r, maxl_nxt;
  logic              done_r, done_nxt;
  logic [RUN_W-1:0]  k_r, k_nxt;
  logic              ov_r, ov_nxt;
  out_item_t         out_r, out_nxt;

  logic take, adv, emit, last_col, last_cnt, last;

  assign out_empty = ~ov_r;
  assign out_item  = out_r;
  assign take      = ~ov_r | out_pop;
  assign adv       = ~cmd_empty & take;
  assign last_col  = (col_r == maxc_r);
  assign last_cnt  = ({1'b0, k_r} + 1'b1) == {1'b0, head.count};
  assign last      = last_col | last_cnt;

  always_comb begin
    col_nxt  = col_r;
    line_nxt = line_r;
    maxc_nxt = maxc_r;
    maxl_nxt = maxl_r;
    done_nxt = done_r;
    k_nxt    = k_r;
    out_nxt  = out_r;
    emit     = 1'b0;
    cmd_pop  = 1'b0;
    if (adv) begin
      case (head.kind)
        CMD_HDR: begin
          maxc_nxt = head.max_col;
          maxl_nxt = head.max_line;
          col_nxt  = '0;
          line_nxt = '0;
          done_nxt = 1'b0;
          k_nxt    = '0;
          cmd_pop  = 1'b1;
        end
        CMD_BAD: begin
          emit               = 1'b1;
          out_nxt            = '0;
          out_nxt.bad_format = 1'b1;
          done_nxt           = 1'b1;
          cmd_pop            = 1'b1;
        end
        CMD_RUN: begin
          if (done_r) begin
            // drop everything past the last row
            cmd_pop = 1'b1;
          end else begin
            emit               = 1'b1;
            out_nxt.pixel      = head.value;
            out_nxt.column     = col_r;
            out_nxt.line       = line_r;
            out_nxt.run_end    = last;
            out_nxt.image_end  = last_col && (line_r == maxl_r);
            out_nxt.bad_format = 1'b0;
            if (last_col) begin
              col_nxt = '0;
              if (line_r == maxl_r) begin
                done_nxt = 1'b1;
              end else begin
                line_nxt = line_r + 1'b1;
              end
            end else begin
              col_nxt = col_r + 1'b1;
            end
            k_nxt   = last ? '0 : k_r + 1'b1;
            cmd_pop = last;
          end
        end
        default: begin
          cmd_pop = 1'b1;
        end
      endcase
    end
    ov_nxt = take ? emit : ov_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      line_r <= '0;
      done_r <= 1'b0;
      k_r    <= '0;
      ov_r   <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      line_r <= line_nxt;
      done_r <= done_nxt;
      k_r    <= k_nxt;
      ov_r   <= ov_nxt;
    end
    maxc_r <= maxc_nxt;
    maxl_r <= maxl_nxt;
    if (take && emit) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== src/pcx_rle_image_decoder_top.sv =====
// PCX 8-bit RLE image decoder, top level.
// Depends on pcx_pkg, pcx_front, pcx_cmd_fifo and pcx_back.
//
// Usage:
//   Input queue: drive in_item (one file byte plus a start_of_file mark) and
//   raise in_push; the word is taken at a clock edge where in_full is low.
//   The first 128 bytes after reset or after a start_of_file mark form the
//   header; byte 127 closes the check and, if it fails, yields one word with
//   bad_format set and all other fields zero.
//   Result queue: while out_empty is low, out_item holds the oldest pixel with
//   its column and line, run_end on the last pixel caused by one input byte
//   and image_end on the final pixel; it is taken at an edge where out_pop
//   is high.
// Timing:
//   At the edge that takes a byte, the parser writes its command into the
//   command queue; the expander then moves each pixel into the output
//   register. Literal pixel bytes flow at one byte per cycle while out_pop
//   keeps the output register free. A run yields one pixel per cycle on
//   the same terms; the command queue fills behind it and then in_full holds
//   the input. A passing header close uses the expander but emits no pixel.
// Reset and stall:
//   rst_n (synchronous, active low) empties both queues and restarts the
//   header parse. A stalled receiver holds the output word; the expander
//   and then the input side hold until out_pop frees the output register.
module pcx_rle_image_decoder_top import pcx_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 640,
  parameter int unsigned MAX_HEIGHT = 480
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_item,
  output logic      in_full,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  // front to queue
  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_full;

  // queue to back
  logic cmd_empty;
  logic cmd_pop;
  cmd_t cmd_head;

  // Parse header and bytes, classify into commands
  pcx_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .cmd_full (cmd_full),
    .in_full  (in_full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  // Decouple parser from expander so each can stall on its own
  pcx_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .pop      (cmd_pop),
    .full     (cmd_full),
    .empty    (cmd_empty),
    .head     (cmd_head)
  );

  // Expand runs into pixels, track position, clip at row end
  pcx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .head      (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// ===== dv/pcx_rle_image_decoder_checker.sv =====
// Scoreboard for the PCX RLE image decoder: decodes accepted file bytes into
// expected pixel words and compares them with the words popped from the block.
// Depends on pcx_pkg.
module pcx_rle_image_decoder_checker import pcx_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 640,
  parameter int unsigned MAX_HEIGHT = 480
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_item,
  input  logic      in_full,
  input  logic      out_empty,
  input  logic      out_pop,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]        hdr_pos;
  logic [15:0]       xmax_r;
  logic [15:0]       ymax_r;
  logic              hdr_ok;
  logic [COL_W-1:0]  col_cnt;
  logic [LINE_W-1:0] row_cnt;
  logic [RUN_W-1:0]  run_len;
  logic              run_armed;
  logic              done;

  out_item_t expected_pixels[$];
  int        mismatches = 0;

  task automatic reset_parse();
    hdr_pos   = '0;
    xmax_r    = '0;
    ymax_r    = '0;
    hdr_ok    = 1'b1;
    col_cnt   = '0;
    row_cnt   = '0;
    run_len   = '0;
    run_armed = 1'b0;
    done      = 1'b0;
  endtask

  // Work out the pixel words that one file byte causes.
  task automatic decode_byte(input in_item_t w);
    out_item_t   px;
    logic [7:0]  d;
    int unsigned count;
    int unsigned room;
    int unsigned n;
    d = w.data_byte;
    if (w.start_of_file) reset_parse();
    if (hdr_pos < HDR_BYTES) begin
      case (hdr_pos)
        HDR_OFS_MANUF:   if (d != HDR_MANUF) hdr_ok = 1'b0;
        HDR_OFS_VERSION: if (d != HDR_VERSION) hdr_ok = 1'b0;
        HDR_OFS_ENCODE:  if (d != HDR_ENCODE) hdr_ok = 1'b0;
        HDR_OFS_BPP:     if (d != HDR_BPP) hdr_ok = 1'b0;
        HDR_OFS_XMAX_LO: xmax_r[7:0] = d;
        HDR_OFS_XMAX_HI: xmax_r[15:8] = d;
        HDR_OFS_YMAX_LO: ymax_r[7:0] = d;
        HDR_OFS_YMAX_HI: ymax_r[15:8] = d;
        default: ;
      endcase
      hdr_pos = hdr_pos + 8'd1;
      if (hdr_pos == HDR_BYTES) begin
        // negative extents fail along with oversize ones
        if (xmax_r[15] || xmax_r >= MAX_WIDTH) hdr_ok = 1'b0;
        if (ymax_r[15] || ymax_r >= MAX_HEIGHT) hdr_ok = 1'b0;
        if (!hdr_ok) begin
          done          = 1'b1;
          px            = '0;
          px.bad_format = 1'b1;
          expected_pixels.push_back(px);
        end
      end
      return;
    end
    if (done) return;
    if (run_armed) begin
      count     = run_len;
      run_armed = 1'b0;
      run_len   = '0;
    end else if ((d & RUN_MARK) == RUN_MARK) begin
      run_len   = RUN_W'(d & RUN_MASK);
      run_armed = 1'b1;
      return;
    end else begin
      count = 1;
    end
    // clip the run at the end of the row
    room = xmax_r + 1 - col_cnt;
    n    = (count < room) ? count : room;
    for (int k = 0; k < n; k++) begin
      px         = '0;
      px.pixel   = d;
      px.column  = col_cnt;
      px.line    = row_cnt;
      px.run_end = (k + 1 == n);
      col_cnt    = col_cnt + 1'b1;
      if (col_cnt > xmax_r) begin
        col_cnt = '0;
        if (row_cnt >= ymax_r) begin
          done         = 1'b1;
          px.image_end = 1'b1;
        end else begin
          row_cnt = row_cnt + 1'b1;
        end
      end
      expected_pixels.push_back(px);
    end
  endtask

  function automatic string word_str(input out_item_t w);
    return $sformatf("pixel %0d column %0d line %0d run_end %0b image_end %0b bad %0b",
                     w.pixel, w.column, w.line, w.run_end, w.image_end, w.bad_format);
  endfunction

  task automatic check_pixel(input out_item_t got);
    out_item_t want;
    if (expected_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected word: %s", word_str(got));
      return;
    end
    want = expected_pixels.pop_front();
    if (got.pixel !== want.pixel || got.column !== want.column ||
        got.line !== want.line || got.run_end !== want.run_end ||
        got.image_end !== want.image_end || got.bad_format !== want.bad_format) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch at %0t", $realtime);
        $display("  expected %s", word_str(want));
        $display("  actual   %s", word_str(got));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_parse();
      expected_pixels.delete();
    end else begin
      if (in_push && !in_full) decode_byte(in_item);
      if (out_pop && !out_empty) check_pixel(out_item);
    end
    pending_words <= expected_pixels.size();
    fail_count    <= mismatches;
  end

endmodule

// ===== dv/tb_pcx_rle_image_decoder_top.sv =====
// Testbench top for the PCX RLE image decoder: streams PCX files into the
// block and pops pixel words, with checking done by pcx_rle_image_decoder_checker.
// Depends on pcx_pkg, pcx_rle_image_decoder_top and the checker.
module tb_pcx_rle_image_decoder_top;
  import pcx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_W = 640;
  localparam int unsigned MAX_H = 480;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  in_item_t  in_item = '0;
  logic      in_full;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_item;

  int   fail_count;
  int   pending_words;
  // calm: both sides run flat out, no idle cycles
  logic calm = 1'b0;

  pcx_rle_image_decoder_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  pcx_rle_image_decoder_checker #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_item      (in_item),
    .in_full      (in_full),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_item     (out_item),
    .fail_count   (fail_count),
    .pending_words(pending_words)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one file byte and hold it until the block takes the word.
  // Push stays high between back-to-back words; idle cycles drop it.
  task automatic push_byte(input logic [7:0] b, input logic sof);
    while (!calm && $urandom_range(99) < 20) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= '{data_byte: b, start_of_file: sof};
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Drop push and hold off until every expected pixel word has been popped.
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  // Send the first nbytes of a 128-byte header. Checked offsets take the given
  // values; everything else is random filler.
  task automatic send_header(input logic [15:0] xm, input logic [15:0] ym,
                             input logic [7:0] manuf, input logic [7:0] ver,
                             input logic [7:0] enc, input logic [7:0] bpp,
                             input logic sof, input int nbytes);
    logic [7:0] b;
    for (int i = 0; i < nbytes; i++) begin
      case (8'(i))
        HDR_OFS_MANUF:   b = manuf;
        HDR_OFS_VERSION: b = ver;
        HDR_OFS_ENCODE:  b = enc;
        HDR_OFS_BPP:     b = bpp;
        HDR_OFS_XMAX_LO: b = xm[7:0];
        HDR_OFS_XMAX_HI: b = xm[15:8];
        HDR_OFS_YMAX_LO: b = ym[7:0];
        HDR_OFS_YMAX_HI: b = ym[15:8];
        default:         b = 8'($urandom_range(255));
      endcase
      push_byte(b, sof && i == 0);
    end
  endtask

  task automatic send_good_header(input logic [15:0] xm, input logic [15:0] ym,
                                  input logic sof);
    send_header(xm, ym, HDR_MANUF, HDR_VERSION, HDR_ENCODE, HDR_BPP, sof, HDR_BYTES);
  endtask

  task automatic send_junk(input int n);
    repeat (n) push_byte(8'($urandom_range(255)), 1'b0);
  endtask

  // Stream pixel data for a w x h image as literals and runs. Track the row
  // position only to know when the image is full; stop early after stop_after
  // tokens to leave a file cut short, else append trail bytes past the end.
  task automatic send_body(input int w, input int h, input int run_pct,
                           input int long_pct, input int stop_after, input int trail);
    int col;
    int row;
    int cnt;
    int n;
    int tokens;
    col    = 0;
    row    = 0;
    tokens = 0;
    while (row < h && tokens < stop_after) begin
      if ($urandom_range(99) < run_pct) begin
        cnt = ($urandom_range(99) < long_pct) ? $urandom_range(32, 63)
                                              : $urandom_range(0, 8);
        push_byte(RUN_MARK | 8'(cnt), 1'b0);
        push_byte(8'($urandom_range(255)), 1'b0);
      end else begin
        cnt = 1;
        push_byte(8'($urandom_range(0, 191)), 1'b0);
      end
      n = (cnt < w - col) ? cnt : w - col;
      col += n;
      if (col == w) begin
        col = 0;
        row++;
      end
      tokens++;
    end
    if (row == h) send_junk(trail);
  endtask

  // Receiver: pop at random, with an occasional long stall so the result
  // queue backs up and in_full pushes back on the sender.
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(199) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(5, 40)) @(posedge clk);
      end else begin
        out_pop <= calm || ($urandom_range(99) >= 20);
      end
    end
  end

  initial begin
    int cut;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First file right after reset carries no start mark: 4 x 24 image.
    send_good_header(16'd3, 16'd23, 1'b0);
    push_byte(8'h00, 1'b0);               // literal at column 0
    push_byte(RUN_MARK | 8'd5, 1'b0);     // run of 5 clipped at row end
    push_byte(8'hFF, 1'b0);
    push_byte(8'hBF, 1'b0);               // largest literal value
    push_byte(RUN_MARK, 1'b0);            // zero-length run eats its value byte
    push_byte(8'h12, 1'b0);
    push_byte(8'hFF, 1'b0);               // run of 63, clipped, closes row 1
    push_byte(8'hC3, 1'b0);
    // Remaining rows with both sides running flat out.
    calm = 1'b1;
    send_body(4, 22, 30, 20, 1000, 0);
    calm = 1'b0;
    push_byte(8'h55, 1'b0);               // ignored: past the last row
    push_byte(RUN_MARK | 8'd7, 1'b0);     // ignored pending run count
    push_byte(8'h33, 1'b0);
    drain();

    // Header cut short by the next file's start mark.
    cut = $urandom_range(4, 20);
    send_header(16'd3, 16'd1, HDR_MANUF, HDR_VERSION, HDR_ENCODE, HDR_BPP, 1'b1, cut);

    // One header check fails; bytes after it give nothing.
    case ($urandom_range(7))
      0: send_header(16'd3, 16'd1, 8'($urandom_range(11, 255)), HDR_VERSION,
                     HDR_ENCODE, HDR_BPP, 1'b1, HDR_BYTES);
      1: send_header(16'd3, 16'd1, HDR_MANUF, 8'd4, HDR_ENCODE, HDR_BPP,
                     1'b1, HDR_BYTES);
      2: send_header(16'd3, 16'd1, HDR_MANUF, HDR_VERSION, 8'($urandom_range(2, 255)),
                     HDR_BPP, 1'b1, HDR_BYTES);
      3: send_header(16'd3, 16'd1, HDR_MANUF, HDR_VERSION, HDR_ENCODE, 8'd4,
                     1'b1, HDR_BYTES);
      4: send_good_header(16'($urandom_range(16'h8000, 16'hFFFF)), 16'd1, 1'b1);
      5: send_good_header(16'd3, 16'($urandom_range(16'h8000, 16'hFFFF)), 1'b1);
      6: send_good_header(16'($urandom_range(MAX_W, MAX_W + 8)), 16'd1, 1'b1);
      default: send_good_header(16'd3, 16'($urandom_range(MAX_H, MAX_H + 8)), 1'b1);
    endcase
    send_junk(2);

    // ---- wind down ----
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("[pcx_rle_image_decoder_top] OK");
    end else begin
      $display("[pcx_rle_image_decoder_top] ERROR");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #(5_000_000);
    $display("[pcx_rle_image_decoder_top] ERROR");
    $finish;
  end

endmodule

// ===== pcx_rle_image_decoder_top.f =====
src/pcx_pkg.sv
src/pcx_front.sv
src/pcx_cmd_fifo.sv
src/pcx_back.sv
src/pcx_rle_image_decoder_top.sv
dv/pcx_rle_image_decoder_checker.sv
dv/tb_pcx_rle_image_decoder_top.sv
